// File: design/dq_pkg.sv
`default_nettype none
package dq_pkg;

  // Ring geometry
  localparam int DEPTH = 16;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int PTR_W = IDX_W + 1;
  localparam int VAL_W = 32;

  // Command codes
  localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [2:0] CMD_PUSH_BACK  = 3'd1;
  localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [2:0] CMD_POP_BACK   = 3'd3;
  localparam logic [2:0] CMD_DUMP       = 3'd4;

  // Status codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  typedef struct packed {
    logic [2:0]              cmd;
    logic signed [VAL_W-1:0] value_in;
  } dq_in_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] value_out;
    logic [1:0]              status;
    logic                    last;
  } dq_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_OUT
  } dq_state_t;

  typedef enum logic [2:0] {
    PTR_HOLD,
    PTR_PUSH_FRONT,
    PTR_PUSH_BACK,
    PTR_POP_FRONT,
    PTR_POP_BACK
  } dq_ptr_op_t;

  typedef enum logic [1:0] {
    RD_FRONT,
    RD_BACK,
    RD_NEXT
  } dq_rd_sel_t;

  typedef enum logic [1:0] {
    EMIT_ECHO,
    EMIT_EMPTY,
    EMIT_FULL,
    EMIT_RDATA
  } dq_emit_sel_t;

  // Controller to datapath
  typedef struct packed {
    logic         load;
    dq_ptr_op_t   ptr_op;
    logic         rd_en;
    dq_rd_sel_t   rd_sel;
    logic         cnt_clr;
    logic         cnt_inc;
    logic         emit;
    dq_emit_sel_t emit_sel;
    logic         emit_last;
  } dq_ctl_t;

  // Datapath to controller
  typedef struct packed {
    logic [2:0] cmd;
    logic       full;
    logic       empty;
    logic       dump_last;
    logic       out_free;
  } dq_stat_t;

endpackage
`default_nettype wire

// File: design/dq_ctrl.sv
`default_nettype none
module dq_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire dq_pkg::dq_stat_t st,
  output dq_pkg::dq_ctl_t       ctl
);

  dq_pkg::dq_state_t state_r, state_nxt;

  logic is_dump;
  assign is_dump = (st.cmd == dq_pkg::CMD_DUMP);

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dq_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      dq_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = dq_pkg::ST_EXEC;
      end
      dq_pkg::ST_EXEC: begin
        case (st.cmd)
          dq_pkg::CMD_PUSH_FRONT, dq_pkg::CMD_PUSH_BACK: begin
            if (st.out_free) state_nxt = dq_pkg::ST_IDLE;
          end
          dq_pkg::CMD_POP_FRONT, dq_pkg::CMD_POP_BACK, dq_pkg::CMD_DUMP: begin
            if (!st.empty) state_nxt = dq_pkg::ST_OUT;
            else if (st.out_free) state_nxt = dq_pkg::ST_IDLE;
          end
          default: state_nxt = dq_pkg::ST_IDLE;
        endcase
      end
      dq_pkg::ST_OUT: begin
        if (st.out_free && !(is_dump && !st.dump_last)) state_nxt = dq_pkg::ST_IDLE;
      end
      default: state_nxt = dq_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_stall      = 1'b1;
    ctl.load      = 1'b0;
    ctl.ptr_op    = dq_pkg::PTR_HOLD;
    ctl.rd_en     = 1'b0;
    ctl.rd_sel    = dq_pkg::RD_FRONT;
    ctl.cnt_clr   = 1'b0;
    ctl.cnt_inc   = 1'b0;
    ctl.emit      = 1'b0;
    ctl.emit_sel  = dq_pkg::EMIT_ECHO;
    ctl.emit_last = 1'b1;
    case (state_r)
      dq_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        ctl.load = in_valid;
      end
      dq_pkg::ST_EXEC: begin
        case (st.cmd)
          dq_pkg::CMD_PUSH_FRONT, dq_pkg::CMD_PUSH_BACK: begin
            ctl.emit = st.out_free;
            if (st.full) begin
              ctl.emit_sel = dq_pkg::EMIT_FULL;
            end else if (st.out_free) begin
              ctl.ptr_op = (st.cmd == dq_pkg::CMD_PUSH_FRONT) ?
                           dq_pkg::PTR_PUSH_FRONT : dq_pkg::PTR_PUSH_BACK;
            end
          end
          dq_pkg::CMD_POP_FRONT, dq_pkg::CMD_POP_BACK, dq_pkg::CMD_DUMP: begin
            if (st.empty) begin
              ctl.emit     = st.out_free;
              ctl.emit_sel = dq_pkg::EMIT_EMPTY;
            end else begin
              // issue the first read; pops retire their slot right away
              ctl.rd_en = 1'b1;
              case (st.cmd)
                dq_pkg::CMD_POP_FRONT: ctl.ptr_op = dq_pkg::PTR_POP_FRONT;
                dq_pkg::CMD_POP_BACK: begin
                  ctl.ptr_op = dq_pkg::PTR_POP_BACK;
                  ctl.rd_sel = dq_pkg::RD_BACK;
                end
                default: ctl.cnt_clr = 1'b1;
              endcase
            end
          end
          default: ;
        endcase
      end
      dq_pkg::ST_OUT: begin
        ctl.emit      = st.out_free;
        ctl.emit_sel  = dq_pkg::EMIT_RDATA;
        ctl.emit_last = !is_dump || st.dump_last;
        // dump: fetch the following entry while this one goes out
        if (st.out_free && is_dump && !st.dump_last) begin
          ctl.rd_en   = 1'b1;
          ctl.rd_sel  = dq_pkg::RD_NEXT;
          ctl.cnt_inc = 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// File: design/dq_datapath.sv
`default_nettype none
module dq_datapath (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire dq_pkg::dq_in_t  in_data,
  output dq_pkg::dq_out_t      out_data,
  output logic                 out_valid,
  input  wire logic            out_stall,
  input  wire dq_pkg::dq_ctl_t ctl,
  output dq_pkg::dq_stat_t     st
);

  localparam int IDX_W = dq_pkg::IDX_W;
  localparam int CNT_W = dq_pkg::CNT_W;
  localparam int PTR_W = dq_pkg::PTR_W;
  localparam int VAL_W = dq_pkg::VAL_W;
  localparam logic [PTR_W-1:0] DEPTH_P = PTR_W'(dq_pkg::DEPTH);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(dq_pkg::DEPTH);

  // Reduce a sum below twice the depth to a slot index
  function automatic logic [IDX_W-1:0] ring_wrap(input logic [PTR_W-1:0] a);
    logic [PTR_W-1:0] d;
    d = a - DEPTH_P;
    return (a >= DEPTH_P) ? d[IDX_W-1:0] : a[IDX_W-1:0];
  endfunction

  logic [2:0]              cmd_r;
  logic signed [VAL_W-1:0] val_r;
  logic [IDX_W-1:0]        front_r, front_nxt;
  logic [CNT_W-1:0]        occ_r, occ_nxt;
  logic [IDX_W-1:0]        cnt_r;
  logic signed [VAL_W-1:0] mem [dq_pkg::DEPTH];
  logic signed [VAL_W-1:0] rdata_r;
  logic                    out_valid_r;
  dq_pkg::dq_out_t         out_r, out_nxt;
  logic [IDX_W-1:0]        addr_pf, addr_pb, addr_back, addr_next, rd_addr;
  logic                    out_free;

  // Slot addresses
  assign addr_pf   = ring_wrap(PTR_W'(front_r) + PTR_W'(dq_pkg::DEPTH - 1));
  assign addr_pb   = ring_wrap(PTR_W'(front_r) + PTR_W'(occ_r));
  assign addr_back = ring_wrap(PTR_W'(front_r) + PTR_W'(occ_r) - PTR_W'(1));
  assign addr_next = ring_wrap(PTR_W'(front_r) + PTR_W'(cnt_r) + PTR_W'(1));

  always_comb begin
    case (ctl.rd_sel)
      dq_pkg::RD_BACK: rd_addr = addr_back;
      dq_pkg::RD_NEXT: rd_addr = addr_next;
      default:         rd_addr = front_r;
    endcase
  end

  // Request capture
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r <= in_data.cmd;
      val_r <= in_data.value_in;
    end
  end

  // Front pointer and occupancy
  always_comb begin
    front_nxt = front_r;
    occ_nxt   = occ_r;
    case (ctl.ptr_op)
      dq_pkg::PTR_PUSH_FRONT: begin
        front_nxt = addr_pf;
        occ_nxt   = occ_r + CNT_W'(1);
      end
      dq_pkg::PTR_PUSH_BACK: occ_nxt = occ_r + CNT_W'(1);
      dq_pkg::PTR_POP_FRONT: begin
        front_nxt = ring_wrap(PTR_W'(front_r) + PTR_W'(1));
        occ_nxt   = occ_r - CNT_W'(1);
      end
      dq_pkg::PTR_POP_BACK: occ_nxt = occ_r - CNT_W'(1);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      occ_r   <= '0;
    end else begin
      front_r <= front_nxt;
      occ_r   <= occ_nxt;
    end
  end

  // Dump position
  always_ff @(posedge clk) begin
    if (ctl.cnt_clr) cnt_r <= '0;
    else if (ctl.cnt_inc) cnt_r <= cnt_r + IDX_W'(1);
  end

  // Slot memory, registered read
  always_ff @(posedge clk) begin
    if (ctl.ptr_op == dq_pkg::PTR_PUSH_FRONT) mem[addr_pf] <= val_r;
    else if (ctl.ptr_op == dq_pkg::PTR_PUSH_BACK) mem[addr_pb] <= val_r;
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) rdata_r <= mem[rd_addr];
  end

  // Result register
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    out_nxt.last = ctl.emit_last;
    case (ctl.emit_sel)
      dq_pkg::EMIT_EMPTY: begin
        out_nxt.value_out = '0;
        out_nxt.status    = dq_pkg::STAT_EMPTY;
      end
      dq_pkg::EMIT_FULL: begin
        out_nxt.value_out = '0;
        out_nxt.status    = dq_pkg::STAT_FULL;
      end
      dq_pkg::EMIT_RDATA: begin
        out_nxt.value_out = rdata_r;
        out_nxt.status    = dq_pkg::STAT_OK;
      end
      default: begin
        out_nxt.value_out = val_r;
        out_nxt.status    = dq_pkg::STAT_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Status to controller
  assign st.cmd       = cmd_r;
  assign st.full      = (occ_r == DEPTH_C);
  assign st.empty     = (occ_r == '0);
  assign st.dump_last = ((CNT_W'(cnt_r) + CNT_W'(1)) == occ_r);
  assign st.out_free  = out_free;

  // Checks
  a_occ_range: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= DEPTH_C)
    else $error("occupancy above depth");

  a_front_range: assert property (@(posedge clk) disable iff (!rst_n)
    PTR_W'(front_r) < DEPTH_P)
    else $error("front index out of range");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.emit |-> out_free)
    else $error("result overwritten while held");

  a_push_grow: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.ptr_op == dq_pkg::PTR_PUSH_FRONT || ctl.ptr_op == dq_pkg::PTR_PUSH_BACK)
    |=> occ_r == $past(occ_r) + CNT_W'(1))
    else $error("push did not grow occupancy");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    st.full |-> !(ctl.ptr_op == dq_pkg::PTR_PUSH_FRONT ||
                  ctl.ptr_op == dq_pkg::PTR_PUSH_BACK))
    else $error("push into full queue");

endmodule
`default_nettype wire

// File: design/double_ended_queue.sv
// Results: push and error results pass the request register and then the result
//   register; pop and dump results also pass the registered slot-memory read.
// Requests: one request at a time, a new one taken only once the last is done;
//   a dump gives one result per cycle from the ring while out_stall is low.
// Reset: synchronous, active low; the queue comes up empty with front index zero;
//   slot contents are undefined until written and never reach the output.
`default_nettype none
module double_ended_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire dq_pkg::dq_in_t in_data,
  output logic                out_valid,
  input  wire logic           out_stall,
  output dq_pkg::dq_out_t     out_data
);

  dq_pkg::dq_ctl_t  ctl;
  dq_pkg::dq_stat_t st;

  // Sequencer
  dq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .ctl      (ctl)
  );

  // Ring buffer and result register
  dq_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .ctl       (ctl),
    .st        (st)
  );

endmodule
`default_nettype wire

// File: dv/testbench.sv
`default_nettype none
module testbench;

  localparam int CLK_PERIOD    = 12;
  localparam int RESET_CYCLES  = 12;
  localparam int RAND_REQS     = 310;
  localparam int SETTLE_CYCLES = 2 * dq_pkg::DEPTH + 8;
  localparam int LIMIT_CYCLES  = 600000;

  // codes the block has no name for; it must ignore them
  localparam logic [2:0] CMD_UNUSED_LO = 3'd5;
  localparam logic [2:0] CMD_UNUSED_HI = 3'd7;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            in_valid = 1'b0;
  logic            in_stall;
  dq_pkg::dq_in_t  in_data = '0;
  logic            out_valid;
  logic            out_stall = 1'b0;
  dq_pkg::dq_out_t out_data;

  double_ended_queue dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always begin
    #(CLK_PERIOD / 2) clk = 1'b1;
    #(CLK_PERIOD / 2) clk = 1'b0;
  end

  // results still owed by the block, oldest first
  dq_pkg::dq_out_t expected_results[$];

  // deque state as the block should hold it
  logic signed [dq_pkg::VAL_W-1:0] ring_vals [dq_pkg::DEPTH];
  int head_idx = 0;
  int fill_cnt = 0;

  int n_errors   = 0;
  int n_requests = 0;
  int n_results  = 0;
  int n_dumps    = 0;
  int n_full     = 0;
  int n_empty    = 0;
  int peak_fill  = 0;

  // Apply one request to the deque state; optionally queue the results it owes.
  function automatic void advance_deque(input dq_pkg::dq_in_t req, input bit record);
    dq_pkg::dq_out_t res;
    int slot;
    res = '0;
    res.status = dq_pkg::STAT_OK;
    res.last = 1'b1;
    case (req.cmd)
      dq_pkg::CMD_PUSH_FRONT, dq_pkg::CMD_PUSH_BACK: begin
        if (fill_cnt >= dq_pkg::DEPTH) begin
          res.status = dq_pkg::STAT_FULL;
        end else begin
          if (req.cmd == dq_pkg::CMD_PUSH_FRONT) begin
            head_idx = (head_idx + dq_pkg::DEPTH - 1) % dq_pkg::DEPTH;
            slot = head_idx;
          end else begin
            slot = (head_idx + fill_cnt) % dq_pkg::DEPTH;
          end
          ring_vals[slot] = req.value_in;
          fill_cnt++;
          res.value_out = req.value_in;
        end
        if (record) expected_results.push_back(res);
      end
      dq_pkg::CMD_POP_FRONT, dq_pkg::CMD_POP_BACK: begin
        if (fill_cnt == 0) begin
          res.status = dq_pkg::STAT_EMPTY;
        end else begin
          if (req.cmd == dq_pkg::CMD_POP_FRONT) begin
            slot = head_idx;
            head_idx = (head_idx + 1) % dq_pkg::DEPTH;
          end else begin
            slot = (head_idx + fill_cnt - 1) % dq_pkg::DEPTH;
          end
          res.value_out = ring_vals[slot];
          fill_cnt--;
        end
        if (record) expected_results.push_back(res);
      end
      dq_pkg::CMD_DUMP: begin
        if (fill_cnt == 0) begin
          res.status = dq_pkg::STAT_EMPTY;
          if (record) expected_results.push_back(res);
        end else if (record) begin
          for (int i = 0; i < fill_cnt; i++) begin
            res.value_out = ring_vals[(head_idx + i) % dq_pkg::DEPTH];
            res.last = (i == fill_cnt - 1);
            expected_results.push_back(res);
          end
        end
      end
      default: ;
    endcase
    if (fill_cnt > peak_fill) peak_fill = fill_cnt;
  endfunction

  // Present one request and hold it until accepted; valid stays up afterwards.
  task automatic send_request(input dq_pkg::dq_in_t req, input bit typed,
                              input dq_pkg::dq_out_t typed_res);
    in_valid <= 1'b1;
    in_data <= req;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    if (typed) begin
      advance_deque(req, 1'b0);
      expected_results.push_back(typed_res);
    end else begin
      advance_deque(req, 1'b1);
    end
    n_requests++;
    if (req.cmd == dq_pkg::CMD_DUMP) n_dumps++;
  endtask

  // Drop valid and hold off until every owed result has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // Sender bursts: random burst lengths, random gaps, some stretches with no gaps.
  int burst_left = 0;
  task automatic pace_sender();
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(16, 1);
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(6, 1);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
  endtask

  // Directed table: a row may repeat with value stepping by one; typed rows
  // carry their own expectation, the rest go through the predictor.
  typedef struct packed {
    logic [2:0]                      cmd;
    logic signed [dq_pkg::VAL_W-1:0] value;
    logic [4:0]                      reps;
    logic                            typed;
    logic signed [dq_pkg::VAL_W-1:0] exp_value;
    logic [1:0]                      exp_status;
  } dir_row_t;

  dir_row_t dir_rows[$];

  function automatic void add_row(input logic [2:0] cmd,
                                  input logic [dq_pkg::VAL_W-1:0] value,
                                  input int reps, input bit typed,
                                  input logic [dq_pkg::VAL_W-1:0] exp_value,
                                  input logic [1:0] exp_status);
    dir_row_t row;
    row.cmd = cmd;
    row.value = value;
    row.reps = 5'(reps);
    row.typed = typed;
    row.exp_value = exp_value;
    row.exp_status = exp_status;
    dir_rows.push_back(row);
  endfunction

  // Random value, weighted toward zero and the signed extremes.
  function automatic logic [dq_pkg::VAL_W-1:0] pick_value();
    case ($urandom_range(7))
      0: return '0;
      1: return 32'h7fff_ffff;
      2: return 32'h8000_0000;
      3: return 32'hffff_ffff;
      4: return $urandom_range(255);
      default: return $urandom;
    endcase
  endfunction

  // Receiver stall pattern: free-running, random light, random heavy, periodic.
  logic [9:0] stall_cyc = '0;
  always @(posedge clk) begin
    stall_cyc <= stall_cyc + 1'b1;
    case (stall_cyc[9:8])
      2'd0: out_stall <= 1'b0;
      2'd1: out_stall <= ($urandom_range(3) == 0);
      2'd2: out_stall <= ($urandom_range(9) < 6);
      default: out_stall <= (stall_cyc[3:0] < 4'd5);
    endcase
  end

  // Result checker
  always @(posedge clk) begin : check_results
    dq_pkg::dq_out_t want;
    if (rst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
      n_results++;
      if (expected_results.size() == 0) begin
        $error("unexpected result: value_out %0d status %0d last %0d",
               out_data.value_out, out_data.status, out_data.last);
        n_errors++;
      end else begin
        want = expected_results.pop_front();
        if (want.status == dq_pkg::STAT_FULL) n_full++;
        if (want.status == dq_pkg::STAT_EMPTY) n_empty++;
        if (out_data.value_out !== want.value_out) begin
          $error("value_out: expected %0d, actual %0d", want.value_out, out_data.value_out);
          n_errors++;
        end
        if (out_data.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, out_data.status);
          n_errors++;
        end
        if (out_data.last !== want.last) begin
          $error("last: expected %0d, actual %0d", want.last, out_data.last);
          n_errors++;
        end
      end
    end
  end

  // Stimulus
  initial begin : stimulus
    dir_row_t row;
    dq_pkg::dq_in_t req;
    dq_pkg::dq_out_t want;
    int n_rand;
    int phase_left;
    bit fill_phase;
    int pick;

    // empty deque after reset
    add_row(dq_pkg::CMD_POP_FRONT, 32'h0, 1, 1'b1, 32'h0, dq_pkg::STAT_EMPTY);
    add_row(dq_pkg::CMD_POP_BACK, 32'h0, 1, 1'b1, 32'h0, dq_pkg::STAT_EMPTY);
    add_row(dq_pkg::CMD_DUMP, 32'h0, 1, 1'b1, 32'h0, dq_pkg::STAT_EMPTY);
    add_row(CMD_UNUSED_LO, 32'h1234_5678, 1, 1'b0, 32'h0, dq_pkg::STAT_OK);
    // zero and the signed extremes, front pointer wraps below zero
    add_row(dq_pkg::CMD_PUSH_BACK, 32'h0, 1, 1'b1, 32'h0, dq_pkg::STAT_OK);
    add_row(dq_pkg::CMD_PUSH_FRONT, 32'h7fff_ffff, 1, 1'b1, 32'h7fff_ffff,
            dq_pkg::STAT_OK);
    add_row(dq_pkg::CMD_PUSH_BACK, 32'h8000_0000, 1, 1'b1, 32'h8000_0000,
            dq_pkg::STAT_OK);
    add_row(dq_pkg::CMD_PUSH_FRONT, 32'hffff_ffff, 1, 1'b1, 32'hffff_ffff,
            dq_pkg::STAT_OK);
    // fill to capacity from both ends
    add_row(dq_pkg::CMD_PUSH_FRONT, 32'h5555_5550, 6, 1'b1, 32'h5555_5550,
            dq_pkg::STAT_OK);
    add_row(dq_pkg::CMD_PUSH_BACK, 32'haaaa_aaa0, 6, 1'b1, 32'haaaa_aaa0,
            dq_pkg::STAT_OK);
    // full: pushes dropped
    add_row(dq_pkg::CMD_PUSH_FRONT, 32'h1, 1, 1'b1, 32'h0, dq_pkg::STAT_FULL);
    add_row(dq_pkg::CMD_PUSH_BACK, 32'h2, 1, 1'b1, 32'h0, dq_pkg::STAT_FULL);
    add_row(CMD_UNUSED_HI, 32'hdead_beef, 1, 1'b0, 32'h0, dq_pkg::STAT_OK);
    add_row(dq_pkg::CMD_DUMP, 32'h0, 1, 1'b0, 32'h0, dq_pkg::STAT_OK);
    add_row(dq_pkg::CMD_POP_FRONT, 32'h0, 1, 1'b0, 32'h0, dq_pkg::STAT_OK);
    add_row(dq_pkg::CMD_POP_BACK, 32'h0, 1, 1'b0, 32'h0, dq_pkg::STAT_OK);

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < dir_rows.size(); r++) begin
      row = dir_rows[r];
      for (int k = 0; k < row.reps; k++) begin
        pace_sender();
        req.cmd = row.cmd;
        req.value_in = row.value + k;
        want.value_out = row.exp_value + k;
        want.status = row.exp_status;
        want.last = 1'b1;
        send_request(req, row.typed, want);
      end
    end
    wait_drained();

    // Random part: alternate fill-leaning and drain-leaning stretches so the
    // deque swings between empty and full.
    n_rand = 0;
    phase_left = 0;
    fill_phase = 1'b1;
    want = '0;
    while (n_rand < RAND_REQS) begin
      if (phase_left == 0) begin
        phase_left = $urandom_range(50, 20);
        fill_phase = !fill_phase;
      end
      phase_left--;
      pick = $urandom_range(99);
      if (pick < 5) begin
        req.cmd = CMD_UNUSED_LO + 3'($urandom_range(2));
      end else if (pick < 14) begin
        req.cmd = dq_pkg::CMD_DUMP;
      end else if ((pick < 70) == fill_phase) begin
        req.cmd = $urandom_range(1) ? dq_pkg::CMD_PUSH_FRONT : dq_pkg::CMD_PUSH_BACK;
      end else begin
        req.cmd = $urandom_range(1) ? dq_pkg::CMD_POP_FRONT : dq_pkg::CMD_POP_BACK;
      end
      req.value_in = pick_value();
      pace_sender();
      send_request(req, 1'b0, want);
      if (req.cmd <= dq_pkg::CMD_DUMP) n_rand++;
      // hold off once mid-run until the block has caught up
      if (n_rand == RAND_REQS / 2 && req.cmd <= dq_pkg::CMD_DUMP) wait_drained();
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Covered %0d requests (%0d dumps), %0d results checked, peak fill %0d of %0d",
             n_requests, n_dumps, n_results, peak_fill, dq_pkg::DEPTH);
    $display("Dropped pushes on full: %0d, requests on empty: %0d", n_full, n_empty);
    if (n_errors == 0) begin
      $display("PASS double_ended_queue");
    end else begin
      $display("FAIL double_ended_queue");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(CLK_PERIOD * LIMIT_CYCLES);
    $display("FAIL double_ended_queue");
    $finish;
  end

endmodule
`default_nettype wire

// File: sim.f
design/dq_pkg.sv
design/dq_ctrl.sv
design/dq_datapath.sv
design/double_ended_queue.sv
dv/testbench.sv
